FILE: src/dtp_pkg.sv
// types and constants shared by the decimal token parser
`timescale 1ns / 1ps
package dtp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AccW    = ValueW + 4;

  localparam logic [AccW-1:0]   MagLimit = AccW'(36'd3000000000);
  localparam logic [ValueW-1:0] PosLimit = 32'd2147483647;
  localparam logic [ValueW-1:0] NegLimit = 32'd2147483648;

  localparam logic [CharW-1:0] ChNul   = 8'd0;
  localparam logic [CharW-1:0] ChTab   = 8'd9;
  localparam logic [CharW-1:0] ChCr    = 8'd13;
  localparam logic [CharW-1:0] ChSpace = 8'd32;
  localparam logic [CharW-1:0] ChPlus  = 8'd43;
  localparam logic [CharW-1:0] ChMinus = 8'd45;
  localparam logic [CharW-1:0] ChZero  = 8'd48;
  localparam logic [CharW-1:0] ChNine  = 8'd57;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGNED = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_NODIGIT  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_TRAILING = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef struct packed {
    phase_e             phase;
    logic               is_negative;
    logic [ValueW-1:0]  magnitude;
  } parse_state_t;

  typedef struct packed {
    logic               valid;
    logic [ValueW-1:0]  value;
    status_e            status;
  } parse_result_t;

endpackage

FILE: src/dtp_if.sv
// valid/ready channel interfaces for the byte input and the token result
`timescale 1ns / 1ps
interface dtp_in_if import dtp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface dtp_out_if import dtp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic signed [ValueW-1:0] value;
  logic [StatusW-1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

FILE: src/dtp_step.sv
// one parse step: next token state and optional result for one byte
`timescale 1ns / 1ps
module dtp_step import dtp_pkg::*; (
  input  parse_state_t  state_i,
  input  logic [CharW-1:0] char_i,
  output parse_state_t  state_o,
  output parse_result_t res_o
);

  logic              is_digit;
  logic              is_blank;
  logic [3:0]        digit;
  logic [AccW-1:0]   mag_next;
  parse_state_t      cleared;

  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_blank = (char_i == ChSpace) || ((char_i >= ChTab) && (char_i <= ChCr));
  assign digit    = 4'(char_i - ChZero);
  assign mag_next = {1'b0, state_i.magnitude, 3'b000} + {3'b000, state_i.magnitude, 1'b0}
                  + {{(AccW-4){1'b0}}, digit};

  assign cleared = '{phase: PH_SKIP, is_negative: 1'b0, magnitude: '0};

  always_comb begin
    state_o = state_i;
    res_o   = '{valid: 1'b0, value: '0, status: ST_OK};
    case (state_i.phase)
      PH_SIGNED: begin
        if (is_digit) begin
          state_o.magnitude = {{(ValueW-4){1'b0}}, digit};
          state_o.phase     = PH_DIGITS;
        end else begin
          state_o = cleared;
          res_o   = '{valid: 1'b1, value: '0, status: ST_NODIGIT};
        end
      end
      PH_DIGITS: begin
        state_o = cleared;
        if (is_digit) begin
          if (mag_next > MagLimit) begin
            res_o = '{valid: 1'b1, value: '0, status: ST_OVERFLOW};
          end else begin
            state_o           = state_i;
            state_o.magnitude = mag_next[ValueW-1:0];
          end
        end else if ((char_i == ChSpace) || (char_i == ChNul)) begin
          if (state_i.is_negative) begin
            if (state_i.magnitude > NegLimit) begin
              res_o = '{valid: 1'b1, value: '0, status: ST_RANGE};
            end else begin
              res_o = '{valid: 1'b1, value: '0 - state_i.magnitude, status: ST_OK};
            end
          end else if (state_i.magnitude > PosLimit) begin
            res_o = '{valid: 1'b1, value: '0, status: ST_RANGE};
          end else begin
            res_o = '{valid: 1'b1, value: state_i.magnitude, status: ST_OK};
          end
        end else begin
          res_o = '{valid: 1'b1, value: '0, status: ST_TRAILING};
        end
      end
      default: begin
        // skip phase and the unused code
        if (is_blank) begin
          state_o.phase = PH_SKIP;
        end else if ((char_i == ChMinus) || (char_i == ChPlus)) begin
          state_o.is_negative = (char_i == ChMinus);
          state_o.magnitude   = '0;
          state_o.phase       = PH_SIGNED;
        end else if (is_digit) begin
          state_o.is_negative = 1'b0;
          state_o.magnitude   = {{(ValueW-4){1'b0}}, digit};
          state_o.phase       = PH_DIGITS;
        end else begin
          state_o = cleared;
          res_o   = '{valid: 1'b1, value: '0, status: ST_NODIGIT};
        end
      end
    endcase
  end

endmodule

FILE: src/decimal_integer_token_parser_core.sv
// signed decimal token parser: ascii bytes in, 32-bit values with status out
//
// in_i carries one ascii byte per item; out_o carries one token result per item
// (value plus status, value valid only for status ok).
// leading blanks are skipped, one optional sign is taken, then digits; a space
// or nul closes the token. errors give a status code and restart the parse.
// bytes that do not finish a token produce no result item.
// a result is registered: the byte that caused it passes the input register,
// then the parse logic, then the result register.
// one byte per cycle unless a byte waits for the result register; the parse
// step is combinational (multiply-by-ten add and compare, 36 bits wide).
// a waiting result does not block the input: bytes that produce no result keep
// flowing; only a byte that would produce a second result holds in the input
// register until the result register drains, with in_i.ready low meanwhile.
// reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to the skip phase with sign and magnitude cleared.
`timescale 1ns / 1ps
module decimal_integer_token_parser_core import dtp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtp_in_if.sink     in_i,
  dtp_out_if.source  out_o
);

  logic              s1_valid_q, s1_valid_d;
  logic [CharW-1:0]  s1_char_q;
  parse_state_t      state_q, state_d;
  parse_state_t      step_state;
  parse_result_t     step_res;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q;
  status_e           out_status_q;
  logic              out_free;
  logic              s1_adv;
  logic              in_take;

  dtp_step u_step (
    .state_i (state_q),
    .char_i  (s1_char_q),
    .state_o (step_state),
    .res_o   (step_res)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && (!step_res.valid || out_free);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_take     = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_take || (s1_valid_q && !s1_adv);
  assign state_d     = s1_adv ? step_state : state_q;
  assign out_valid_d = (out_valid_q && !out_o.ready) || (s1_adv && step_res.valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_SKIP, is_negative: 1'b0, magnitude: '0};
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= in_i.character;
    end
    if (s1_adv && step_res.valid) begin
      out_value_q  <= step_res.value;
      out_status_q <= step_res.status;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

endmodule

FILE: test/tb.sv
// testbench for the decimal token parser: directed and random byte streams checked against a token predictor
`timescale 1ns / 1ps
module tb import dtp_pkg::*; ();

  localparam int unsigned ItemCount  = 1550;
  localparam int unsigned CalmTail   = 200;
  localparam int unsigned QuietLimit = 2000;

  typedef struct {
    logic [ValueW-1:0] value;
    status_e           status;
  } token_t;

  class token_scoreboard;
    phase_e            phase;
    logic              negative;
    logic [ValueW-1:0] mag;
    token_t            pending_tokens[$];
    int unsigned       fails;

    function new();
      clear();
      fails = 0;
    endfunction

    function void clear();
      phase    = PH_SKIP;
      negative = 1'b0;
      mag      = '0;
    endfunction

    function int unsigned pending();
      return pending_tokens.size();
    endfunction

    function void close_token(logic [ValueW-1:0] v, status_e s);
      token_t t;
      t.value  = v;
      t.status = s;
      pending_tokens.push_back(t);
      clear();
    endfunction

    function void note_byte(logic [CharW-1:0] c);
      logic            is_dig;
      logic            is_blank;
      logic [3:0]      d;
      logic [AccW-1:0] acc;
      is_dig   = (c >= ChZero) && (c <= ChNine);
      is_blank = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
      d        = 4'(c - ChZero);
      case (phase)
        PH_SIGNED: begin
          if (!is_dig) begin
            close_token('0, ST_NODIGIT);
          end else begin
            mag   = ValueW'(d);
            phase = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (is_dig) begin
            acc = AccW'(mag) * AccW'(10) + AccW'(d);
            if (acc > MagLimit) close_token('0, ST_OVERFLOW);
            else mag = acc[ValueW-1:0];
          end else if (c == ChSpace || c == ChNul) begin
            if (negative) begin
              if (mag > NegLimit) close_token('0, ST_RANGE);
              else close_token(-mag, ST_OK);
            end else begin
              if (mag > PosLimit) close_token('0, ST_RANGE);
              else close_token(mag, ST_OK);
            end
          end else begin
            close_token('0, ST_TRAILING);
          end
        end
        default: begin
          // skip phase, unused code 3 behaves the same
          if (is_blank) begin
            phase = PH_SKIP;
          end else if (c == ChMinus || c == ChPlus) begin
            negative = (c == ChMinus);
            mag      = '0;
            phase    = PH_SIGNED;
          end else if (is_dig) begin
            negative = 1'b0;
            mag      = ValueW'(d);
            phase    = PH_DIGITS;
          end else begin
            close_token('0, ST_NODIGIT);
          end
        end
      endcase
    endfunction

    function void check_token(logic [ValueW-1:0] v, logic [StatusW-1:0] s);
      token_t t;
      if (pending_tokens.size() == 0) begin
        $error("unexpected result: value %0d status %0d", $signed(v), s);
        fails++;
        return;
      end
      t = pending_tokens.pop_front();
      if (v !== t.value) begin
        $error("value: expected %0d, actual %0d", $signed(t.value), $signed(v));
        fails++;
      end
      if (s !== t.status) begin
        $error("status: expected %0d, actual %0d", t.status, s);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_en = 1'b1;
  int unsigned sent = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  token_scoreboard sb;

  dtp_in_if  in_if ();
  dtp_out_if out_if ();

  decimal_integer_token_parser_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // accepted items on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.character);
      if (out_if.valid && out_if.ready) sb.check_token(out_if.value, out_if.status);
    end
  end

  // result stalls in random bursts while idle_en is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 13);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_byte(input logic [CharW-1:0] c);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.character <= c;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  task automatic send_token();
    logic [CharW-1:0] text[$];
    longint unsigned  num;
    string            digits;
    int unsigned      r;
    repeat ($urandom_range(0, 2))
      text.push_back($urandom_range(0, 1) ? ChSpace : CharW'($urandom_range(9, 13)));
    r = $urandom_range(0, 3);
    if (r == 0) text.push_back(ChMinus);
    else if (r == 1) text.push_back(ChPlus);
    case ($urandom_range(0, 9))
      0, 1, 2: num = 64'($urandom_range(0, 999));
      3:       num = 64'($urandom_range(0, 9));
      4, 5:    num = 64'($urandom);
      6:       num = {$urandom, $urandom} % 64'd100000000000;
      default: begin
        // magnitudes near the range and overflow limits
        case ($urandom_range(0, 7))
          0: num = 64'd0;
          1: num = 64'd2147483647;
          2: num = 64'd2147483648;
          3: num = 64'd2147483649;
          4: num = 64'd2999999999;
          5: num = 64'd3000000000;
          6: num = 64'd3000000001;
          default: num = 64'd4294967295;
        endcase
      end
    endcase
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) text.push_back(ChZero);
    digits = $sformatf("%0d", num);
    foreach (digits[i]) text.push_back(digits[i]);
    r = $urandom_range(0, 19);
    if (r < 9) text.push_back(ChSpace);
    else if (r < 15) text.push_back(ChNul);
    else if (r < 17) text.push_back(CharW'($urandom));
    else text.push_back(CharW'($urandom_range(9, 13)));
    // stray byte somewhere in the token
    if ($urandom_range(0, 9) == 0)
      text.insert($urandom_range(0, text.size()), CharW'($urandom));
    foreach (text[i]) put_byte(text[i]);
  endtask

  initial begin
    logic [CharW-1:0] directed[$];
    bit paused;
    directed = '{ChSpace, ChTab, ChPlus, "7", ChSpace,
                 ChMinus, "0", ChNul,
                 "x", ChNul,
                 ChPlus, ChMinus,
                 ChMinus, ChTab,
                 "5", "a",
                 "9", 8'd11,
                 8'hff,
                 "1", 8'h80,
                 ChSpace};
    paused          = 1'b0;
    sb              = new();
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.character = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) put_byte(directed[i]);

    while (sent < ItemCount) begin
      idle_en = (sent + CalmTail < ItemCount) && ($urandom_range(0, 3) != 0);
      repeat (8) send_token();
      if (!paused && sent > ItemCount / 2) begin
        // hold the input until every result has drained
        in_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        paused = 1'b1;
      end
    end
    idle_en = 1'b0;
    in_if.valid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/dtp_pkg.sv
src/dtp_if.sv
src/dtp_step.sv
src/decimal_integer_token_parser_core.sv
test/tb.sv
